FILE: sv/bmts_pkg.sv
package bmts_pkg;

    localparam int MELODY_LENGTH = 35;
    localparam int ROM_NOTES     = 35;
    localparam int POS_W         = 6;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_BEEP   = 2'd1,
        ACT_MELODY = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] beep_frequency;
        logic [15:0] beep_duration_ms;
    } req_t;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_frequency;
        logic        receiver_paused;
        logic        busy_res;
    } res_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } note_t;

    // melody table; positions past the stored notes read as a zero-length rest
    function automatic note_t note_rom(input logic [POS_W-1:0] idx);
        note_t n;
        case (idx)
            6'd0:  n = '{16'd196, 16'd260};
            6'd1:  n = '{16'd196, 16'd260};
            6'd2:  n = '{16'd233, 16'd170};
            6'd3:  n = '{16'd262, 16'd170};
            6'd4:  n = '{16'd196, 16'd260};
            6'd5:  n = '{16'd0,   16'd60};
            6'd6:  n = '{16'd196, 16'd260};
            6'd7:  n = '{16'd196, 16'd260};
            6'd8:  n = '{16'd349, 16'd170};
            6'd9:  n = '{16'd370, 16'd170};
            6'd10: n = '{16'd196, 16'd260};
            6'd11: n = '{16'd0,   16'd60};
            6'd12: n = '{16'd196, 16'd260};
            6'd13: n = '{16'd196, 16'd260};
            6'd14: n = '{16'd233, 16'd170};
            6'd15: n = '{16'd262, 16'd170};
            6'd16: n = '{16'd196, 16'd260};
            6'd17: n = '{16'd0,   16'd60};
            6'd18: n = '{16'd196, 16'd260};
            6'd19: n = '{16'd196, 16'd260};
            6'd20: n = '{16'd349, 16'd170};
            6'd21: n = '{16'd370, 16'd170};
            6'd22: n = '{16'd196, 16'd350};
            6'd23: n = '{16'd0,   16'd100};
            6'd24: n = '{16'd392, 16'd260};
            6'd25: n = '{16'd392, 16'd260};
            6'd26: n = '{16'd466, 16'd170};
            6'd27: n = '{16'd523, 16'd170};
            6'd28: n = '{16'd392, 16'd260};
            6'd29: n = '{16'd0,   16'd60};
            6'd30: n = '{16'd392, 16'd260};
            6'd31: n = '{16'd392, 16'd260};
            6'd32: n = '{16'd349, 16'd170};
            6'd33: n = '{16'd370, 16'd170};
            6'd34: n = '{16'd392, 16'd400};
            default: n = '{16'd0, 16'd0};
        endcase
        return n;
    endfunction

endpackage

FILE: sv/beep_and_melody_tone_sequencer_top.sv
// a request's result is registered and shown in the cycle after it is accepted
// throughput: one request per cycle; the state update and note table lookup
// sit in a single stage ahead of the result register
// a request is held off only while a result is waiting and stalled
// reset (rst_n low, asynchronous): idle, silent, receiver released, no result pending
module beep_and_melody_tone_sequencer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bmts_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_stall,
    output bmts_pkg::res_t  res
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BEEP,
        MODE_MELODY
    } mode_t;

    mode_t                        mode_reg, mode_next;
    logic [bmts_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]                  remain_reg, remain_next;
    logic                         sounding_reg, sounding_next;
    logic [15:0]                  freq_reg, freq_next;
    logic                         pause_reg, pause_next;
    logic                         res_valid_reg;
    bmts_pkg::res_t               res_reg, res_next;

    logic                         accept;
    logic                         last_ms;
    logic [bmts_pkg::POS_W-1:0]   pos_inc;
    logic [bmts_pkg::POS_W-1:0]   note_idx;
    logic                         note_start;
    bmts_pkg::note_t              note;

    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign last_ms  = (remain_reg[15:1] == 15'd0);
    assign pos_inc  = pos_reg + 1'b1;
    assign note_idx = (req.action == bmts_pkg::ACT_MELODY) ? '0 : pos_inc;
    assign note     = bmts_pkg::note_rom(note_idx);

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        remain_next   = remain_reg;
        sounding_next = sounding_reg;
        freq_next     = freq_reg;
        pause_next    = pause_reg;
        note_start    = 1'b0;
        case (req.action)
            bmts_pkg::ACT_BEEP:
            begin
                mode_next     = MODE_BEEP;
                pause_next    = 1'b1;
                sounding_next = 1'b1;
                freq_next     = req.beep_frequency;
                remain_next   = req.beep_duration_ms;
            end
            bmts_pkg::ACT_MELODY:
            begin
                mode_next  = MODE_MELODY;
                pos_next   = '0;
                note_start = 1'b1;
            end
            bmts_pkg::ACT_STOP:
            begin
                mode_next = MODE_IDLE;
            end
            default:
            begin
                case (mode_reg)
                    MODE_BEEP:
                    begin
                        if (last_ms)
                            mode_next = MODE_IDLE;
                        else
                            remain_next = remain_reg - 16'd1;
                    end
                    MODE_MELODY:
                    begin
                        if (last_ms)
                        begin
                            pos_next = pos_inc;
                            // wrap of the position counter also ends the melody
                            if (pos_inc == '0 ||
                                {1'b0, pos_inc} >= (bmts_pkg::POS_W+1)'(bmts_pkg::MELODY_LENGTH))
                                mode_next = MODE_IDLE;
                            else
                                note_start = 1'b1;
                        end
                        else
                        begin
                            remain_next = remain_reg - 16'd1;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        endcase

        if (note_start)
        begin
            pause_next    = 1'b1;
            sounding_next = (note.freq != 16'd0);
            freq_next     = note.freq;
            remain_next   = note.dur;
        end

        if (mode_next == MODE_IDLE)
        begin
            sounding_next = 1'b0;
            freq_next     = 16'd0;
            pause_next    = 1'b0;
            remain_next   = 16'd0;
        end

        res_next.tone_on         = sounding_next;
        res_next.tone_frequency  = sounding_next ? freq_next : 16'd0;
        res_next.receiver_paused = pause_next;
        res_next.busy_res        = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pos_reg       <= '0;
            remain_reg    <= 16'd0;
            sounding_reg  <= 1'b0;
            freq_reg      <= 16'd0;
            pause_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                pos_reg       <= pos_next;
                remain_reg    <= remain_next;
                sounding_reg  <= sounding_next;
                freq_reg      <= freq_next;
                pause_reg     <= pause_next;
                res_reg       <= res_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_tone_needs_pause: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.tone_on) |-> res.receiver_paused)
        else $error("tone sounding while receiver released");

    a_silent_freq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.tone_on) |-> (res.tone_frequency == 16'd0))
        else $error("frequency shown while silent");

    a_pause_tracks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.receiver_paused == res.busy_res))
        else $error("receiver pause out of step with mode");

    a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.action == bmts_pkg::ACT_STOP)
        |=> (res_valid && !res.busy_res && !res.tone_on))
        else $error("stop request did not go idle");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MELODY)
        |-> ({1'b0, pos_reg} < (bmts_pkg::POS_W+1)'(bmts_pkg::MELODY_LENGTH)))
        else $error("note position past melody end");
`endif

endmodule

FILE: verif/tone_sequencer_monitor.sv
`timescale 1ns / 1ps

module tone_sequencer_monitor
    import bmts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_stall,
    input  req_t  req,
    input  logic  res_valid,
    input  logic  res_stall,
    input  res_t  res,
    output int    mismatches,
    output int    open_count
);

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_BEEP   = 2'd1,
        SEQ_MELODY = 2'd2
    } seq_mode_t;

    // {hz, ms} per note, frequency 0 is a rest
    note_t song [0:ROM_NOTES-1] = '{
        {16'd196, 16'd260}, {16'd196, 16'd260}, {16'd233, 16'd170},
        {16'd262, 16'd170}, {16'd196, 16'd260}, {16'd0,   16'd60},
        {16'd196, 16'd260}, {16'd196, 16'd260}, {16'd349, 16'd170},
        {16'd370, 16'd170}, {16'd196, 16'd260}, {16'd0,   16'd60},
        {16'd196, 16'd260}, {16'd196, 16'd260}, {16'd233, 16'd170},
        {16'd262, 16'd170}, {16'd196, 16'd260}, {16'd0,   16'd60},
        {16'd196, 16'd260}, {16'd196, 16'd260}, {16'd349, 16'd170},
        {16'd370, 16'd170}, {16'd196, 16'd350}, {16'd0,   16'd100},
        {16'd392, 16'd260}, {16'd392, 16'd260}, {16'd466, 16'd170},
        {16'd523, 16'd170}, {16'd392, 16'd260}, {16'd0,   16'd60},
        {16'd392, 16'd260}, {16'd392, 16'd260}, {16'd349, 16'd170},
        {16'd370, 16'd170}, {16'd392, 16'd400}
    };

    seq_mode_t         mode;
    logic [POS_W-1:0]  pos;
    logic [15:0]       left_ms;
    logic              sounding;
    logic [15:0]       pitch;
    logic              paused;

    res_t              expected_q[$];

    function automatic void fall_silent();
        sounding = 1'b0;
        pitch    = '0;
        paused   = 1'b0;
        mode     = SEQ_IDLE;
        left_ms  = '0;
    endfunction

    function automatic void load_note();
        note_t n;
        if (pos >= MELODY_LENGTH) begin
            fall_silent();
        end
        else begin
            n = (pos < ROM_NOTES) ? song[pos] : '0;
            paused   = 1'b1;
            sounding = (n.freq != 0);
            pitch    = n.freq;
            left_ms  = n.dur;
        end
    endfunction

    function automatic res_t step_sequencer(input req_t r);
        res_t o;
        case (r.action)
            ACT_BEEP:
            begin
                paused   = 1'b1;
                sounding = 1'b1;
                pitch    = r.beep_frequency;
                mode     = SEQ_BEEP;
                left_ms  = r.beep_duration_ms;
            end
            ACT_MELODY:
            begin
                pos  = '0;
                mode = SEQ_MELODY;
                load_note();
            end
            ACT_STOP:
            begin
                fall_silent();
            end
            default:
            begin
                // one millisecond passes; zero or one left means this tick ends it
                if (mode == SEQ_BEEP) begin
                    if (left_ms <= 1)
                        fall_silent();
                    else
                        left_ms = left_ms - 1'b1;
                end
                else if (mode == SEQ_MELODY) begin
                    if (left_ms <= 1) begin
                        pos = pos + 1'b1;
                        if (pos == 0 || pos >= MELODY_LENGTH)
                            fall_silent();
                        else
                            load_note();
                    end
                    else begin
                        left_ms = left_ms - 1'b1;
                    end
                end
            end
        endcase
        o.tone_on         = sounding;
        o.tone_frequency  = sounding ? pitch : 16'd0;
        o.receiver_paused = paused;
        o.busy_res        = (mode != SEQ_IDLE);
        return o;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            mode     = SEQ_IDLE;
            pos      = '0;
            left_ms  = '0;
            sounding = 1'b0;
            pitch    = '0;
            paused   = 1'b0;
            mismatches = 0;
            expected_q.delete();
            open_count <= 0;
        end
        else begin
            // a result always belongs to a request taken on an earlier edge
            if (res_valid && !res_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result with nothing expected, got %p", $time, res);
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("tone_on", 16'(want.tone_on), 16'(res.tone_on));
                    check_field("tone_frequency", want.tone_frequency, res.tone_frequency);
                    check_field("receiver_paused", 16'(want.receiver_paused),
                                16'(res.receiver_paused));
                    check_field("busy_res", 16'(want.busy_res), 16'(res.busy_res));
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(step_sequencer(req));
            open_count <= expected_q.size();
        end
    end

endmodule

FILE: verif/beep_and_melody_tone_sequencer_top_tb.sv
`timescale 1ns / 1ps

module beep_and_melody_tone_sequencer_top_tb;
    import bmts_pkg::*;

    localparam int RAND_ITEMS       = 550;
    localparam int CALM_ITEMS       = 100;
    // the first note is 260 ms, a few more ticks reach into the second
    localparam int FIRST_NOTE_TICKS = 265;
    localparam int CYCLE_LIMIT      = 1000000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req       = '0;
    logic  res_valid;
    logic  res_stall = 1'b0;
    res_t  res;

    logic  quiet      = 1'b0;
    int    stall_left = 0;
    int    sent       = 0;
    int    mismatches;
    int    open_count;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    beep_and_melody_tone_sequencer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    tone_sequencer_monitor u_tone_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .mismatches (mismatches),
        .open_count (open_count)
    );

    // receiver back-pressure in bursts of random length
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0) begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else begin
            res_stall <= 1'b0;
        end
    end

    // valid stays up between back-to-back requests, it only drops for a gap
    task automatic send(input action_t act, input logic [15:0] hz, input logic [15:0] ms);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{act, hz, ms};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent = sent + 1;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send(ACT_TICK, 16'($urandom_range(0, 16'hFFFF)),
                        16'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic random_burst();
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                if ($urandom_range(0, 3) == 0)
                    send(ACT_BEEP, 16'($urandom_range(0, 16'hFFFF)),
                         16'($urandom_range(0, 16'hFFFF)));
                else
                    send(ACT_BEEP, 16'($urandom_range(0, 16'hFFFF)),
                         16'($urandom_range(0, 24)));
                run_ticks($urandom_range(0, 30));
            end
            3, 4, 5:
            begin
                send(ACT_MELODY, 16'($urandom_range(0, 16'hFFFF)),
                     16'($urandom_range(0, 16'hFFFF)));
                run_ticks($urandom_range(1, 40));
            end
            6:
                send(ACT_STOP, 16'($urandom_range(0, 16'hFFFF)),
                     16'($urandom_range(0, 16'hFFFF)));
            7:
                run_ticks($urandom_range(1, 20));
            default:
                send(action_t'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                     16'($urandom_range(0, 16'hFFFF)));
        endcase
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle behavior, beep lengths zero, one, two and maximum, frequency extremes
        send(ACT_TICK, 16'hFFFF, 16'hFFFF);
        send(ACT_STOP, 16'h0000, 16'h0000);
        send(ACT_BEEP, 16'h0000, 16'd0);
        send(ACT_TICK, 16'h0000, 16'h0000);
        send(ACT_BEEP, 16'hFFFF, 16'd1);
        send(ACT_TICK, 16'h1234, 16'h4321);
        send(ACT_BEEP, 16'd1, 16'd2);
        run_ticks(2);
        send(ACT_BEEP, 16'hAAAA, 16'hFFFF);
        send(ACT_TICK, 16'h5555, 16'hAAAA);
        // restarts over whatever is running
        send(ACT_BEEP, 16'h5555, 16'd0);
        send(ACT_MELODY, 16'hFFFF, 16'hFFFF);
        send(ACT_TICK, 16'h0000, 16'h0000);
        send(ACT_MELODY, 16'h0000, 16'h0000);
        send(ACT_STOP, 16'hFFFF, 16'hFFFF);
        send(ACT_MELODY, 16'h0000, 16'h0000);
        send(ACT_BEEP, 16'd440, 16'd3);
        send(ACT_TICK, 16'h0000, 16'h0000);
        send(ACT_STOP, 16'h0000, 16'h0000);
        send(ACT_TICK, 16'h0000, 16'h0000);

        // first note runs out and the second one starts
        send(ACT_MELODY, 16'h0000, 16'h0000);
        run_ticks(FIRST_NOTE_TICKS);

        while (sent < RAND_ITEMS - CALM_ITEMS) random_burst();
        quiet <= 1'b1;
        while (sent < RAND_ITEMS) random_burst();

        req_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
